// File: rtl/assert_macros.svh
// assertion macros used by bmpr4_parser
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/bmpr4_pkg.sv
// types and constants of the rle4 bitmap stream decoder
// used by bmpr4_parser, bmpr4_out_reg and bmp_rle4_stream_decoder_top
`default_nettype none

package bmpr4_pkg;

	localparam int MAX_LINE = 1024;

	localparam logic [10:0] COL_MAX = 11'h7FF;
	localparam logic [7:0]  HI_MASK = 8'hF0;
	localparam logic [7:0]  LO_MASK = 8'h0F;

	// escape codes following a zero count byte
	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_EOI   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

	localparam logic [10:0] WIDTH_RESET  = 11'd320;
	localparam logic [15:0] HEIGHT_RESET = 16'd240;

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_VALUE,
		PH_ESCAPE,
		PH_DX,
		PH_DY,
		PH_ABS,
		PH_PAD
	} phase_t;

	typedef enum logic [1:0] {
		KIND_RUN,
		KIND_LINE,
		KIND_IMAGE,
		KIND_ERROR
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] row;
		logic [10:0] column;
		logic [7:0]  run_length;
		logic [3:0]  first_index;
		logic [3:0]  second_index;
		logic        overrun;
	} result_t;

	typedef struct packed {
		logic       step;
		logic [7:0] data_byte;
	} step_t;

	typedef struct packed {
		logic    emit;
		result_t res;
	} beat_t;

endpackage

`default_nettype wire

// File: rtl/bmpr4_parser.sv
// parse state and per-byte decode of the rle4 stream
// depends on bmpr4_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bmpr4_parser (
	input  wire              clk,
	input  wire              arst_n,
	input  bmpr4_pkg::step_t step_i,
	input  wire  [10:0]      image_width,
	input  wire  [15:0]      image_height,
	output bmpr4_pkg::beat_t beat_o
);
	import bmpr4_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  count_q, count_d;
	logic [10:0] col_q, col_d;
	logic [15:0] row_q, row_d;
	logic [7:0]  abs_left_q, abs_left_d;
	logic        pad_q, pad_d;
	logic [7:0]  dx_q, dx_d;
	logic        finished_q, finished_d;

	logic [7:0]  b;
	logic [7:0]  abs_n;
	logic [7:0]  run_len;
	logic [11:0] run_end;
	logic [12:0] width_eff;
	logic        do_run;
	logic [11:0] delta_col;
	logic [16:0] delta_row;
	logic [8:0]  abs_inc;

	assign b = step_i.data_byte;

	assign abs_n     = (abs_left_q >= 8'd2) ? 8'd2 : abs_left_q;
	assign run_len   = (phase_q == PH_ABS) ? abs_n : count_q;
	assign run_end   = {1'b0, col_q} + {4'b0, run_len};
	assign width_eff = ({2'b0, image_width} > 13'(MAX_LINE)) ? 13'(MAX_LINE)
		: {2'b0, image_width};
	assign delta_col = {1'b0, col_q} + {4'b0, dx_q};
	assign delta_row = {1'b0, row_q} + {9'b0, b};
	assign abs_inc   = {1'b0, b} + 9'd1;

	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		col_d      = col_q;
		row_d      = row_q;
		abs_left_d = abs_left_q;
		pad_d      = pad_q;
		dx_d       = dx_q;
		finished_d = finished_q;
		do_run     = 1'b0;
		beat_o     = '0;
		beat_o.res.row = row_q;

		if (step_i.step && !finished_q) begin
			unique case (phase_q)
				PH_COUNT: begin
					if (b != 8'd0) begin
						count_d = b;
						phase_d = PH_VALUE;
					end else begin
						phase_d = PH_ESCAPE;
					end
				end
				PH_VALUE: begin
					phase_d = PH_COUNT;
					do_run  = 1'b1;
				end
				PH_ESCAPE: begin
					phase_d = PH_COUNT;
					priority if (b == ESC_EOL) begin
						beat_o.emit = 1'b1;
						if (row_q >= image_height) begin
							finished_d      = 1'b1;
							beat_o.res.kind = KIND_ERROR;
						end else begin
							beat_o.res.kind = KIND_LINE;
							row_d = row_q + 16'd1;
							col_d = '0;
						end
					end else if (b == ESC_EOI) begin
						finished_d      = 1'b1;
						beat_o.emit     = 1'b1;
						beat_o.res.kind = KIND_IMAGE;
					end else if (b == ESC_DELTA) begin
						phase_d = PH_DX;
					end else begin
						abs_left_d = b;
						// pad when the packed byte count ceil(n/2) is odd
						pad_d   = abs_inc[1];
						phase_d = PH_ABS;
					end
				end
				PH_DX: begin
					dx_d    = b;
					phase_d = PH_DY;
				end
				PH_DY: begin
					phase_d = PH_COUNT;
					col_d   = delta_col[11] ? COL_MAX : delta_col[10:0];
					if (delta_row > {1'b0, image_height}) begin
						finished_d      = 1'b1;
						beat_o.emit     = 1'b1;
						beat_o.res.kind = KIND_ERROR;
					end else begin
						row_d = delta_row[15:0];
					end
				end
				PH_ABS: begin
					abs_left_d = abs_left_q - abs_n;
					if (abs_left_d == 8'd0) begin
						phase_d = pad_q ? PH_PAD : PH_COUNT;
					end
					do_run = (abs_n != 8'd0);
				end
				PH_PAD: begin
					pad_d   = 1'b0;
					phase_d = PH_COUNT;
				end
				default: begin
					phase_d = PH_COUNT;
				end
			endcase

			if (do_run) begin
				beat_o.emit = 1'b1;
				if (row_q >= image_height) begin
					finished_d      = 1'b1;
					beat_o.res.kind = KIND_ERROR;
				end else begin
					col_d = run_end[11] ? COL_MAX : run_end[10:0];
					beat_o.res.kind         = KIND_RUN;
					beat_o.res.column       = col_q;
					beat_o.res.run_length   = run_len;
					beat_o.res.first_index  = 4'((b & HI_MASK) >> 4);
					beat_o.res.second_index = (run_len > 8'd1) ? 4'(b & LO_MASK) : 4'd0;
					beat_o.res.overrun      = ({1'b0, run_end} > width_eff);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_COUNT;
			count_q    <= '0;
			col_q      <= '0;
			row_q      <= '0;
			abs_left_q <= '0;
			pad_q      <= 1'b0;
			dx_q       <= '0;
			finished_q <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			col_q      <= col_d;
			row_q      <= row_d;
			abs_left_q <= abs_left_d;
			pad_q      <= pad_d;
			dx_q       <= dx_d;
			finished_q <= finished_d;
		end
	end

	`ASSERT_IMPLIES(a_silent_after_end, clk, arst_n, step_i.step && finished_q, !beat_o.emit)
	`ASSERT_NEXT(a_end_latches, clk, arst_n, beat_o.emit && (beat_o.res.kind == KIND_IMAGE || beat_o.res.kind == KIND_ERROR), finished_q)
	`ASSERT_IMPLIES(a_pad_pending, clk, arst_n, phase_q == PH_PAD, pad_q)
	`ASSERT_ALWAYS(a_abs_left, clk, arst_n, (phase_q != PH_ABS) || (abs_left_q != 8'd0))

endmodule

`default_nettype wire

// File: rtl/bmpr4_out_reg.sv
// result register of the decoder, drives the master-side stream
// depends on bmpr4_pkg
`default_nettype none

module bmpr4_out_reg (
	input  wire              clk,
	input  wire              arst_n,
	input  bmpr4_pkg::beat_t beat_i,
	output logic             advance,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [47:0]      m_tdata,
	output logic [1:0]       m_tuser
);
	import bmpr4_pkg::*;

	result_t res_q;

	// register is free when empty or its beat leaves this cycle
	assign advance = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= beat_i.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat_i.emit) begin
			res_q <= beat_i.res;
		end
	end

	assign m_tdata = {4'b0, res_q.overrun, res_q.second_index, res_q.first_index,
		res_q.run_length, res_q.column, res_q.row};
	assign m_tuser = res_q.kind;

endmodule

`default_nettype wire

// File: rtl/bmp_rle4_stream_decoder_top.sv
// rle4 bitmap stream decoder, top level: input register, config registers
// depends on bmpr4_pkg, bmpr4_parser and bmpr4_out_reg
//
// usage:
//   slave side takes one compressed byte per beat on s_tdata[7:0]
//   master side gives one descriptor per beat: m_tuser is the kind
//   (pixel run, line done, image done, error), m_tdata the run fields
//   bytes that cause no descriptor (count, escape, delta, pad) give no beat
//   throughput: one byte per cycle while the receiver takes each beat;
//   the parse logic between the input and result registers is combinational
//   a byte is held in the input register, its descriptor in the result register;
//   when the receiver stalls, the result register holds its beat and the
//   byte in the input register waits, so s_tready stays low until the beat
//   leaves; an empty input register still takes one byte first
//   reset clears the parse state, the row and column, and loads width 320
//   and height 240; after image done or an error all bytes are swallowed
//   until the next reset; cfg_we writes cfg_data to register cfg_index
//   (0 width, 1 height), other indexes are ignored; the user writes only
//   while the decoder is idle, which the block itself does not enforce
`default_nettype none

module bmp_rle4_stream_decoder_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // [15:0] row, [26:16] column, [34:27] run_length,
	                               // [38:35] first_index, [42:39] second_index,
	                               // [43] overrun, [47:44] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	import bmpr4_pkg::*;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic        advance;
	step_t       step;
	beat_t       beat;

	assign s_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IMAGE_WIDTH) begin
				width_q <= cfg_data[10:0];
			end
			if (cfg_index == CFG_IMAGE_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	assign step.step      = v_s1 && advance;
	assign step.data_byte = byte_s1;

	bmpr4_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_i       (step),
		.image_width  (width_q),
		.image_height (height_q),
		.beat_o       (beat)
	);

	bmpr4_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat_i   (beat),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// File: dv/bmp_rle4_checker.sv
// scoreboard for the rle4 bitmap stream decoder: predicts descriptors from the byte
// beats and register writes it sees, then compares them with the master side
// depends on bmpr4_pkg
`default_nettype none

module bmp_rle4_checker
	import bmpr4_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [7:0]  s_tdata,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [47:0] m_tdata,
	input  wire  [1:0]  m_tuser,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	phase_t      ph;
	logic [7:0]  run_count;
	logic [7:0]  abs_left;
	logic        pad_due;
	logic [7:0]  skip_cols;
	logic [10:0] col;
	logic [15:0] row;
	logic        halted;
	logic [10:0] width;
	logic [15:0] height;
	result_t     descr_q [$];
	result_t     want;

	initial mismatches = 0;

	task automatic note_error();
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.row = row;
		halted = 1'b1;
		descr_q.push_back(r);
	endtask

	task automatic note_run(input logic [7:0] len, input logic [7:0] val);
		result_t r;
		int      span;
		int      stop;
		span = (int'(width) < MAX_LINE) ? int'(width) : MAX_LINE;
		stop = int'(col) + int'(len);
		if (row >= height) begin
			note_error();
		end else begin
			r = '0;
			r.kind = KIND_RUN;
			r.row = row;
			r.column = col;
			r.run_length = len;
			r.first_index = 4'((val & HI_MASK) >> 4);
			// a lone pixel has no odd partner
			r.second_index = (len > 8'd1) ? 4'(val & LO_MASK) : 4'd0;
			r.overrun = (stop > span);
			col = (stop > int'(COL_MAX)) ? COL_MAX : 11'(stop);
			descr_q.push_back(r);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		result_t     r;
		int          sum;
		logic [7:0]  n;
		if (!halted) begin
			case (ph)
				PH_COUNT: begin
					if (b != 8'd0) begin
						run_count = b;
						ph = PH_VALUE;
					end else begin
						ph = PH_ESCAPE;
					end
				end
				PH_VALUE: begin
					ph = PH_COUNT;
					note_run(run_count, b);
				end
				PH_ESCAPE: begin
					ph = PH_COUNT;
					if (b == ESC_EOL) begin
						if (row >= height) begin
							note_error();
						end else begin
							r = '0;
							r.kind = KIND_LINE;
							r.row = row;
							descr_q.push_back(r);
							row = row + 16'd1;
							col = '0;
						end
					end else if (b == ESC_EOI) begin
						r = '0;
						r.kind = KIND_IMAGE;
						r.row = row;
						descr_q.push_back(r);
						halted = 1'b1;
					end else if (b == ESC_DELTA) begin
						ph = PH_DX;
					end else begin
						abs_left = b;
						// data bytes are padded out to a whole 16-bit word
						pad_due = 1'(((int'(b) + 1) >> 1) & 1);
						ph = PH_ABS;
					end
				end
				PH_DX: begin
					skip_cols = b;
					ph = PH_DY;
				end
				PH_DY: begin
					ph = PH_COUNT;
					sum = int'(col) + int'(skip_cols);
					col = (sum > int'(COL_MAX)) ? COL_MAX : 11'(sum);
					sum = int'(row) + int'(b);
					if (sum > int'(height))
						note_error();
					else
						row = 16'(sum);
				end
				PH_ABS: begin
					n = (abs_left >= 8'd2) ? 8'd2 : abs_left;
					abs_left = abs_left - n;
					if (abs_left == 8'd0)
						ph = pad_due ? PH_PAD : PH_COUNT;
					if (n != 8'd0)
						note_run(n, b);
				end
				PH_PAD: begin
					pad_due = 1'b0;
					ph = PH_COUNT;
				end
				default: ph = PH_COUNT;
			endcase
		end
	endtask

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatches = mismatches + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_COUNT;
			run_count = '0;
			abs_left = '0;
			pad_due = 1'b0;
			skip_cols = '0;
			col = '0;
			row = '0;
			halted = 1'b0;
			width = WIDTH_RESET;
			height = HEIGHT_RESET;
			descr_q.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (descr_q.size() == 0) begin
					$error("descriptor beat with none expected: kind %0d row %0d",
						m_tuser, m_tdata[15:0]);
					mismatches = mismatches + 1;
				end else begin
					want = descr_q.pop_front();
					check_field("kind", want.kind, m_tuser);
					check_field("row", want.row, m_tdata[15:0]);
					check_field("column", want.column, m_tdata[26:16]);
					check_field("run_length", want.run_length, m_tdata[34:27]);
					check_field("first_index", want.first_index, m_tdata[38:35]);
					check_field("second_index", want.second_index, m_tdata[42:39]);
					check_field("overrun", want.overrun, m_tdata[43]);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width = cfg_data[10:0];
					CFG_IMAGE_HEIGHT: height = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata);
			outstanding <= descr_q.size();
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_bmp_rle4_stream_decoder_top.sv
// testbench top for bmp_rle4_stream_decoder_top: drives compressed byte beats,
// register writes and back-pressure, and gives the verdict
// depends on bmpr4_pkg, bmp_rle4_checker and the decoder rtl
`default_nettype none

module tb_bmp_rle4_stream_decoder_top;
	import bmpr4_pkg::*;

	localparam logic [7:0] ESC_MARK      = 8'd0;
	localparam logic [1:0] CFG_UNUSED_LO = 2'd2;
	localparam logic [1:0] CFG_UNUSED_HI = 2'd3;
	localparam int         DRAIN_CYCLES  = 8;
	localparam int         PHASE_BYTES   = 290;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          mismatches;
	int          outstanding;

	logic        steady = 1'b0;
	int          sent = 0;

	// where the parser stands, so random bytes never end the image early
	phase_t      trk_ph = PH_COUNT;
	logic [7:0]  trk_left = '0;
	logic        trk_pad = 1'b0;
	int          trk_row = 0;
	int          cur_height = int'(HEIGHT_RESET);

	logic [7:0]  opening [0:23] = '{
		8'h01, 8'hFF, 8'h04, 8'h3C, 8'hFF, 8'h5A, 8'hFF, 8'hA5,
		ESC_MARK, ESC_DELTA, 8'hFF, 8'h00,
		ESC_MARK, 8'h03, 8'hF0, 8'h0F,
		ESC_MARK, 8'h05, 8'h12, 8'h34, 8'hC6, 8'h00,
		ESC_MARK, ESC_EOL
	};

	bmp_rle4_stream_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bmp_rle4_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 8);
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic track(input logic [7:0] b);
		case (trk_ph)
			PH_COUNT: trk_ph = (b != ESC_MARK) ? PH_VALUE : PH_ESCAPE;
			PH_ESCAPE: begin
				if (b == ESC_EOL) begin
					trk_row = trk_row + 1;
					trk_ph = PH_COUNT;
				end else if (b == ESC_DELTA) begin
					trk_ph = PH_DX;
				end else if (b == ESC_EOI) begin
					trk_ph = PH_COUNT;
				end else begin
					trk_left = b;
					trk_pad = 1'(((int'(b) + 1) >> 1) & 1);
					trk_ph = PH_ABS;
				end
			end
			PH_DX: trk_ph = PH_DY;
			PH_DY: begin
				trk_row = trk_row + int'(b);
				trk_ph = PH_COUNT;
			end
			PH_ABS: begin
				trk_left = (trk_left > 8'd2) ? trk_left - 8'd2 : 8'd0;
				if (trk_left == 8'd0)
					trk_ph = trk_pad ? PH_PAD : PH_COUNT;
			end
			default: trk_ph = PH_COUNT;
		endcase
	endtask

	// keep image end, line ends past the height and deltas past it out of the random part
	function automatic logic [7:0] tame(input logic [7:0] b);
		if (trk_ph == PH_ESCAPE &&
				(b == ESC_EOI || (b == ESC_EOL && trk_row + 1 >= cur_height)))
			return 8'd4;
		if (trk_ph == PH_DY && trk_row + int'(b) >= cur_height)
			return 8'd0;
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(0, 99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent = sent + 1;
		track(b);
	endtask

	task automatic send_tame(input logic [7:0] b);
		send_byte(tame(b));
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [10:0] w, input logic [15:0] h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= 16'(w);
		@(posedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		// writes past the two registers must leave both alone
		cfg_index <= 2'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI));
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_height = int'(h);
	endtask

	task automatic random_token();
		int pick;
		int n;
		int i;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
			send_tame(8'(n));
			send_tame(8'($urandom));
		end else if (pick < 52) begin
			send_tame(ESC_MARK);
			send_tame(ESC_EOL);
		end else if (pick < 60) begin
			send_tame(ESC_MARK);
			send_tame(ESC_DELTA);
			send_tame(8'($urandom));
			send_tame(8'($urandom_range(0, 3)));
		end else if (pick < 85) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 255) : $urandom_range(3, 24);
			send_tame(ESC_MARK);
			send_tame(8'(n));
			for (i = 0; i < (n + 1) / 2; i++)
				send_tame(8'($urandom));
			if (((n + 1) / 2) % 2 == 1)
				send_tame(8'($urandom));
		end else if (pick < 93) begin
			// cut-short escape: the bytes that follow land in the wrong phase
			send_tame(ESC_MARK);
			if ($urandom_range(0, 1) == 1)
				send_tame(ESC_DELTA);
		end else begin
			repeat ($urandom_range(1, 4)) send_tame(8'($urandom));
		end
	endtask

	initial begin
		int i;
		int p;
		int phase_end;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of width and height still in force here
		for (i = 0; i < 24; i++)
			send_byte(opening[i]);

		for (p = 0; p < 5; p++) begin
			settle();
			case (p)
				0: configure(11'd0, 16'(trk_row + 1));
				1: configure(11'd1024, 16'hFFFF);
				2: configure(11'h7FF, 16'(trk_row + $urandom_range(2, 400)));
				3: configure(11'd1, 16'(trk_row + $urandom_range(1, 40)));
				default: configure(11'($urandom_range(1, 1024)),
					16'($urandom_range(trk_row + 1, 65535)));
			endcase
			steady <= (p == 2);
			phase_end = sent + PHASE_BYTES;
			while (sent < phase_end)
				random_token();
		end
		steady <= 1'b0;

		while (trk_ph != PH_COUNT)
			send_tame(8'($urandom));
		settle();

		// one way out of the image per run, since reset is not repeated
		case ($urandom_range(0, 3))
			0: begin
				send_byte(ESC_MARK);
				send_byte(ESC_EOI);
			end
			1: begin
				configure(11'($urandom_range(1, 1024)),
					($urandom_range(0, 1) == 1) ? 16'd0 : 16'(trk_row));
				send_byte(8'd3);
				send_byte(8'h96);
			end
			2: begin
				configure(11'($urandom_range(1, 1024)), 16'(trk_row));
				send_byte(ESC_MARK);
				send_byte(ESC_EOL);
			end
			default: begin
				configure(11'($urandom_range(1, 1024)), 16'(trk_row + $urandom_range(0, 9)));
				send_byte(ESC_MARK);
				send_byte(ESC_DELTA);
				send_byte(8'($urandom));
				send_byte(8'(cur_height - trk_row + 1));
			end
		endcase

		// swallowed once the image has ended
		repeat (6) send_byte(8'($urandom));
		settle();

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
